/* src/updown_gesture_detector_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the up/down gesture detector
// Concurrent checks on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef UPDOWN_GESTURE_DETECTOR_TOP_MACROS_SVH
`define UPDOWN_GESTURE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication.
`define UGD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/ugd_pkg.sv */
// ---------------------------------------------------------------------------
// ugd_pkg
// Shared constants, register codes, state encoding and structs.
// ---------------------------------------------------------------------------
package ugd_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF     = 32;

    localparam int TIME_MS_W = 32;
    localparam int STEP_W    = 8;
    localparam int DELAY_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int SUM_W     = 9;   // saturating step sums, above any min_steps

    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEPS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 2'd3;

    localparam logic [DELAY_W-1:0] AGE_LIMIT_RST    = 16'd400;
    localparam logic [DELAY_W-1:0] COOLDOWN_RST     = 16'd500;
    localparam logic [STEP_W-1:0]  MIN_STEPS_RST    = 8'd1;
    localparam logic [STEP_W-1:0]  INITIAL_STEP_RST = 8'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_AGE_RD,
        ST_AGE_CHK,
        ST_PUSH_PREV,
        ST_PUSH_NEW,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [DELAY_W-1:0] age_limit;
        logic [DELAY_W-1:0] cooldown;
        logic [STEP_W-1:0]  min_steps;
        logic               init_load;
        logic [STEP_W-1:0]  init_value;
    } cfg_t;

    typedef struct packed {
        logic              play_pause;
        logic              restore_valid;
        logic [STEP_W-1:0] restore_step;
        logic              in_cooldown;
    } result_t;

endpackage

/* src/ugd_hist_mem.sv */
// ---------------------------------------------------------------------------
// ugd_hist_mem
// History memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ugd_hist_mem #(
    parameter int HISTORY_DEPTH = ugd_pkg::HISTORY_DEPTH_DEF,
    parameter int TIME_BITS     = ugd_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
    input  logic [TIME_BITS-1:0]             wr_time,
    input  logic [ugd_pkg::STEP_W-1:0]       wr_step,
    input  logic                             rd_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
    output logic [TIME_BITS-1:0]             rd_time,
    output logic [ugd_pkg::STEP_W-1:0]       rd_step
);

    localparam int WORD_W = TIME_BITS + ugd_pkg::STEP_W;

    logic [WORD_W-1:0] mem [HISTORY_DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_time, wr_step};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_time = rd_word_reg[WORD_W-1:ugd_pkg::STEP_W];
    assign rd_step = rd_word_reg[ugd_pkg::STEP_W-1:0];

endmodule

/* src/ugd_cfg_regs.sv */
// ---------------------------------------------------------------------------
// ugd_cfg_regs
// Configuration registers and the initial-step load strobe.
// ---------------------------------------------------------------------------
module ugd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ugd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ugd_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    output ugd_pkg::cfg_t                   cfg
);

    logic [ugd_pkg::DELAY_W-1:0] age_limit_reg;
    logic [ugd_pkg::DELAY_W-1:0] cooldown_reg;
    logic [ugd_pkg::STEP_W-1:0]  min_steps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_limit_reg <= ugd_pkg::AGE_LIMIT_RST;
            cooldown_reg  <= ugd_pkg::COOLDOWN_RST;
            min_steps_reg <= ugd_pkg::MIN_STEPS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ugd_pkg::REG_AGE_LIMIT:    age_limit_reg <= cfg_wdata;
                ugd_pkg::REG_COOLDOWN:     cooldown_reg  <= cfg_wdata;
                ugd_pkg::REG_MIN_STEPS:    min_steps_reg <= cfg_wdata[ugd_pkg::STEP_W-1:0];
                ugd_pkg::REG_INITIAL_STEP: ;  // lands in the controller's prev_step
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.age_limit  = age_limit_reg;
        cfg.cooldown   = cooldown_reg;
        cfg.min_steps  = min_steps_reg;
        cfg.init_load  = cfg_wr_en && (cfg_index == ugd_pkg::REG_INITIAL_STEP);
        cfg.init_value = cfg_wdata[ugd_pkg::STEP_W-1:0];
    end

endmodule

/* src/ugd_ctrl.sv */
// ---------------------------------------------------------------------------
// ugd_ctrl
// Sequencer: cooldown check, aging, append and gesture scan over the
// circular history kept in ugd_hist_mem.
// ---------------------------------------------------------------------------
module ugd_ctrl #(
    parameter int HISTORY_DEPTH = ugd_pkg::HISTORY_DEPTH_DEF,
    parameter int TIME_BITS     = ugd_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ugd_pkg::cfg_t                    cfg,
    // item in
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [TIME_BITS-1:0]             in_time,
    input  logic [ugd_pkg::STEP_W-1:0]       in_step,
    // result out
    output logic                             res_valid,
    input  logic                             res_take,
    output ugd_pkg::result_t                 res,
    // history memory
    output logic                             mem_wr_en,
    output logic [$clog2(HISTORY_DEPTH)-1:0] mem_wr_addr,
    output logic [TIME_BITS-1:0]             mem_wr_time,
    output logic [ugd_pkg::STEP_W-1:0]       mem_wr_step,
    output logic                             mem_rd_en,
    output logic [$clog2(HISTORY_DEPTH)-1:0] mem_rd_addr,
    input  logic [TIME_BITS-1:0]             mem_rd_time,
    input  logic [ugd_pkg::STEP_W-1:0]       mem_rd_step
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int ADD_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);
    localparam logic [ADD_W-1:0] DEPTH_A  = ADD_W'(HISTORY_DEPTH);
    localparam int SW = ugd_pkg::SUM_W;

    ugd_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0]           head_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [PTR_W-1:0]           idx_reg;
    logic [TIME_BITS-1:0]       now_reg;
    logic [ugd_pkg::STEP_W-1:0] step_reg;
    logic [ugd_pkg::STEP_W-1:0] prev_step_reg;
    logic                       detected_reg;
    logic [TIME_BITS-1:0]       detect_time_reg;
    logic [ugd_pkg::STEP_W-1:0] saved_step_reg;
    logic [ugd_pkg::STEP_W-1:0] last_step_reg;
    logic [ugd_pkg::STEP_W-1:0] oldest_reg;
    logic [SW-1:0]              up_reg;
    logic [SW-1:0]              down_reg;
    logic                       fell_reg;
    ugd_pkg::result_t           res_reg;

    // Circular index: base + offset, folded once into the depth.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [ADD_W-1:0] sum;
        sum = ADD_W'(base) + ADD_W'(off);
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] acc,
                                              input logic [ugd_pkg::STEP_W-1:0] d);
        logic [SW:0] sum;
        sum = {1'b0, acc} + (SW+1)'(d);
        return sum[SW] ? {SW{1'b1}} : sum[SW-1:0];
    endfunction

    logic [PTR_W-1:0]     head_inc;
    logic [PTR_W-1:0]     tail_addr;
    logic [TIME_BITS-1:0] entry_age;
    logic [TIME_BITS-1:0] cool_age;
    logic                 too_old;
    logic                 cool;
    logic                 rise;
    logic                 drop;
    logic [SW-1:0]        up_next;
    logic [SW-1:0]        down_next;
    logic                 match;
    logic                 scan_last;

    assign head_inc  = wrap_add(head_reg, CNT_W'(1));
    assign tail_addr = wrap_add(head_reg, count_reg);
    assign entry_age = now_reg - mem_rd_time;
    assign cool_age  = now_reg - detect_time_reg;
    assign too_old   = entry_age > TIME_BITS'(cfg.age_limit);
    assign cool      = detected_reg && (cool_age < TIME_BITS'(cfg.cooldown));
    assign rise      = (mem_rd_step > last_step_reg) && !fell_reg;
    assign drop      = mem_rd_step < last_step_reg;
    assign up_next   = rise ? sat_add(up_reg, mem_rd_step - last_step_reg) : up_reg;
    assign down_next = drop ? sat_add(down_reg, last_step_reg - mem_rd_step) : down_reg;
    assign match     = (idx_reg != '0)
                       && (up_next >= SW'(cfg.min_steps))
                       && (down_next >= SW'(cfg.min_steps));
    assign scan_last = (CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ugd_pkg::ST_IDLE:      if (in_valid) state_next = ugd_pkg::ST_CHECK;
            ugd_pkg::ST_CHECK:     state_next = cool ? ugd_pkg::ST_OUT : ugd_pkg::ST_AGE_RD;
            ugd_pkg::ST_AGE_RD:    state_next = (count_reg == '0) ? ugd_pkg::ST_PUSH_PREV
                                                                   : ugd_pkg::ST_AGE_CHK;
            ugd_pkg::ST_AGE_CHK:   state_next = too_old ? ugd_pkg::ST_AGE_RD
                                                        : ugd_pkg::ST_PUSH_NEW;
            ugd_pkg::ST_PUSH_PREV: state_next = ugd_pkg::ST_PUSH_NEW;
            ugd_pkg::ST_PUSH_NEW:  state_next = ugd_pkg::ST_SCAN_RD;
            ugd_pkg::ST_SCAN_RD:   state_next = ugd_pkg::ST_SCAN_CHK;
            ugd_pkg::ST_SCAN_CHK:  state_next = (match || scan_last) ? ugd_pkg::ST_OUT
                                                                     : ugd_pkg::ST_SCAN_RD;
            ugd_pkg::ST_OUT:       if (res_take) state_next = ugd_pkg::ST_IDLE;
            default:               state_next = ugd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tail_addr;
        mem_wr_time = now_reg;
        mem_wr_step = step_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = head_reg;
        unique case (state_reg)
            ugd_pkg::ST_IDLE:      in_ready = 1'b1;
            ugd_pkg::ST_AGE_RD:    mem_rd_en = (count_reg != '0);
            ugd_pkg::ST_PUSH_PREV: begin
                mem_wr_en   = 1'b1;
                mem_wr_step = prev_step_reg;
            end
            ugd_pkg::ST_PUSH_NEW:  begin
                mem_wr_en = 1'b1;
                if (count_reg == CNT_FULL) begin
                    mem_wr_addr = head_reg;  // overwrite the oldest slot
                end
            end
            ugd_pkg::ST_SCAN_RD:   begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = wrap_add(head_reg, CNT_W'(idx_reg));
            end
            ugd_pkg::ST_OUT:       res_valid = 1'b1;
            default: ;
        endcase
    end

    assign res = res_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ugd_pkg::ST_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            prev_step_reg   <= ugd_pkg::INITIAL_STEP_RST;
            detected_reg    <= 1'b0;
            detect_time_reg <= '0;
            saved_step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg.init_load) begin
                prev_step_reg <= cfg.init_value;
            end
            unique case (state_reg)
                ugd_pkg::ST_CHECK:     if (cool) count_reg <= '0;
                ugd_pkg::ST_AGE_CHK:   if (too_old) begin
                    head_reg  <= head_inc;
                    count_reg <= count_reg - CNT_W'(1);
                end
                ugd_pkg::ST_PUSH_PREV: count_reg <= count_reg + CNT_W'(1);
                ugd_pkg::ST_PUSH_NEW:  begin
                    prev_step_reg <= step_reg;
                    if (count_reg == CNT_FULL) begin
                        head_reg <= head_inc;
                    end else begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ugd_pkg::ST_SCAN_CHK:  if (match) begin
                    detected_reg    <= 1'b1;
                    detect_time_reg <= now_reg;
                    saved_step_reg  <= oldest_reg;
                    prev_step_reg   <= oldest_reg;
                    count_reg       <= '0;
                end
                default: ;
            endcase
        end
    end

    // Item and scan datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ugd_pkg::ST_IDLE:     begin
                now_reg  <= in_time;
                step_reg <= in_step;
            end
            ugd_pkg::ST_CHECK:    begin
                res_reg.play_pause    <= 1'b0;
                res_reg.restore_valid <= cool;
                res_reg.restore_step  <= cool ? saved_step_reg : '0;
                res_reg.in_cooldown   <= cool;
            end
            ugd_pkg::ST_PUSH_NEW: begin
                idx_reg  <= '0;
                up_reg   <= '0;
                down_reg <= '0;
                fell_reg <= 1'b0;
            end
            ugd_pkg::ST_SCAN_CHK: begin
                last_step_reg <= mem_rd_step;
                idx_reg       <= idx_reg + PTR_W'(1);
                if (idx_reg == '0) begin
                    oldest_reg <= mem_rd_step;
                end else begin
                    up_reg   <= up_next;
                    down_reg <= down_next;
                    fell_reg <= fell_reg || drop;
                end
                if (match) begin
                    res_reg.play_pause    <= 1'b1;
                    res_reg.restore_valid <= 1'b1;
                    res_reg.restore_step  <= oldest_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

/* src/updown_gesture_detector_top.sv */
// ---------------------------------------------------------------------------
// updown_gesture_detector_top
// Detects an up-then-down gesture in a stream of step-change transactions
// and asks for the level to be restored after a detection.
// ---------------------------------------------------------------------------
//
//   channel   | ports                                   | transfer
//   ----------+-----------------------------------------+--------------------
//   input     | s_valid s_ready s_time_ms s_step_index  | valid && ready
//   result    | m_valid m_ready m_play_pause            | valid && ready
//             |   m_restore_valid m_restore_step        |
//             |   m_in_cooldown                         |
//   config    | cfg_wr_en cfg_index cfg_wdata           | wr_en high
//
// One transaction at a time. A cooldown hit goes from the check straight to the result.
// Otherwise aging drops entries older than the age limit, the previous step
//   is pushed first when the history is or becomes empty, the new step is
//   pushed and the entries are scanned: every history read is issued in one
//   state and its registered data is used in the next.
// Reset (aresetn low, synchronous) empties the history and clears the
//   cooldown; no memory clearing pass is needed.
// A stalled result sits in the output register; the next input transaction
//   is still taken and its result waits in the controller until the
//   register frees.
// ---------------------------------------------------------------------------
`include "updown_gesture_detector_top_macros.svh"

module updown_gesture_detector_top #(
    parameter int HISTORY_DEPTH = ugd_pkg::HISTORY_DEPTH_DEF,
    parameter int TIME_BITS     = ugd_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [ugd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ugd_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    // input transactions
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ugd_pkg::TIME_MS_W-1:0]   s_time_ms,
    input  logic [ugd_pkg::STEP_W-1:0]      s_step_index,
    // result transactions
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_play_pause,
    output logic                            m_restore_valid,
    output logic [ugd_pkg::STEP_W-1:0]      m_restore_step,
    output logic                            m_in_cooldown
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);

    ugd_pkg::cfg_t        cfg;
    ugd_pkg::result_t     res;
    logic                 res_valid;
    logic                 out_free;
    logic [TIME_BITS-1:0] in_time;

    logic                       mem_wr_en;
    logic [PTR_W-1:0]           mem_wr_addr;
    logic [TIME_BITS-1:0]       mem_wr_time;
    logic [ugd_pkg::STEP_W-1:0] mem_wr_step;
    logic                       mem_rd_en;
    logic [PTR_W-1:0]           mem_rd_addr;
    logic [TIME_BITS-1:0]       mem_rd_time;
    logic [ugd_pkg::STEP_W-1:0] mem_rd_step;

    logic             m_valid_reg;
    ugd_pkg::result_t m_data_reg;

    // Fit the millisecond stamp to the internal time width; wrap follows it.
    if (TIME_BITS >= ugd_pkg::TIME_MS_W) begin : g_time_ext
        assign in_time = TIME_BITS'(s_time_ms);
    end else begin : g_time_cut
        assign in_time = s_time_ms[TIME_BITS-1:0];
    end

    ugd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ugd_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TIME_BITS     (TIME_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_time (mem_wr_time),
        .wr_step (mem_wr_step),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_time (mem_rd_time),
        .rd_step (mem_rd_step)
    );

    ugd_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TIME_BITS     (TIME_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_time     (in_time),
        .in_step     (s_step_index),
        .res_valid   (res_valid),
        .res_take    (out_free),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_time (mem_wr_time),
        .mem_wr_step (mem_wr_step),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_time (mem_rd_time),
        .mem_rd_step (mem_rd_step)
    );

    // Output register: load when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_play_pause    = m_data_reg.play_pause;
    assign m_restore_valid = m_data_reg.restore_valid;
    assign m_restore_step  = m_data_reg.restore_step;
    assign m_in_cooldown   = m_data_reg.in_cooldown;

    // The controller is busy after each accepted transaction.
    `UGD_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "input accepted on two consecutive cycles")
    // A detection is never a cooldown answer and always restores.
    `UGD_ASSERT_NOW(a_detect_restores, m_valid && m_play_pause,
        m_restore_valid && !m_in_cooldown, "detection without restore")
    // No restore means a zero step.
    `UGD_ASSERT_NOW(a_zero_step, m_valid && !m_restore_valid,
        m_restore_step == '0, "restore step set without restore")

endmodule
